// ===== src/eyq_pkg.sv =====
// Package for the YXZ Euler-angle to quaternion converter.
// Holds the shared widths, fixed-point constants, the CORDIC arctangent table
// and the CORDIC cell state type. Depends on nothing.
package eyq_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int TABLE_LEN         = 24;

    // Widths of the datapath.
    localparam int XY_W   = 34;   // CORDIC x and y, Q30 with headroom
    localparam int PH_W   = 32;   // phase in turn units
    localparam int PROD_W = 48;   // angle times phase constant, modulo 2^48
    localparam int SC_W   = 18;   // sine and cosine, Q15 with headroom
    localparam int Q_W    = 16;   // quaternion outputs, Q1.14

    // round(2^34 / pi), scales a Q3.12 angle to half-angle turn units.
    localparam logic [PROD_W-1:0] PHASE_K = 48'd5468522205;
    localparam logic [PROD_W-1:0] PHASE_RND = 48'd32768;
    // Inverse CORDIC gain in Q30.
    localparam logic signed [XY_W-1:0] GAIN_INV = 34'sd652032874;
    // One eighth of a turn, used to fold the phase to the nearest quadrant.
    localparam logic [PH_W-1:0] EIGHTH_TURN = 32'h2000_0000;
    localparam logic signed [Q_W-1:0] Q14_ONE = 16'sd16384;

    // Quadrant codes.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [PH_W-1:0] z;
        logic [1:0]             quad;
    } cordic_t;

    // atan(2^-i) in turn units (2^32 is one turn).
    function automatic logic [PH_W-1:0] atan_turn(input int idx);
        logic [PH_W-1:0] val;
        case (idx)
            0:       val = 32'h2000_0000;
            1:       val = 32'h12E4_051E;
            2:       val = 32'h09FB_385B;
            3:       val = 32'h0511_11D4;
            4:       val = 32'h028B_0D43;
            5:       val = 32'h0145_D7E1;
            6:       val = 32'h00A2_F61E;
            7:       val = 32'h0051_7C55;
            8:       val = 32'h0028_BE53;
            9:       val = 32'h0014_5F2F;
            10:      val = 32'h000A_2F98;
            11:      val = 32'h0005_17CC;
            12:      val = 32'h0002_8BE6;
            13:      val = 32'h0001_45F3;
            14:      val = 32'h0000_A2FA;
            15:      val = 32'h0000_517D;
            16:      val = 32'h0000_28BE;
            17:      val = 32'h0000_145F;
            18:      val = 32'h0000_0A30;
            19:      val = 32'h0000_0518;
            20:      val = 32'h0000_028C;
            21:      val = 32'h0000_0146;
            22:      val = 32'h0000_00A3;
            23:      val = 32'h0000_0051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/eyq_angle_if.sv =====
// Input channel carrying the three Euler angles, signed Q3.12 radians.
// Depends on eyq_pkg for the default angle width.
interface eyq_angle_if
    import eyq_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] angle_x;
    logic signed [ANGLE_WIDTH-1:0] angle_y;
    logic signed [ANGLE_WIDTH-1:0] angle_z;

    modport source (output valid, output angle_x, output angle_y, output angle_z,
                    input ready);
    modport sink   (input valid, input angle_x, input angle_y, input angle_z,
                    output ready);
endinterface

// ===== src/eyq_quat_if.sv =====
// Output channel carrying the quaternion, signed Q1.14.
// Depends on eyq_pkg for the output width.
interface eyq_quat_if
    import eyq_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] quat_w;
    logic signed [Q_W-1:0] quat_x;
    logic signed [Q_W-1:0] quat_y;
    logic signed [Q_W-1:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

// ===== src/euler_yxz_to_quaternion_top.sv =====
// Top level of the YXZ Euler-angle to quaternion converter.
// Depends on eyq_pkg, eyq_angle_if, eyq_quat_if, eyq_sincos, eyq_cordic_cell.
//
// Usage:
//   Angles arrive on the sink side of an eyq_angle_if channel as three signed
//   Q3.12 radian values; a beat moves when valid and ready are both high.
//   Results leave on the source side of an eyq_quat_if channel as four signed
//   Q1.14 values (w, x, y, z), each saturated to plus or minus 1.0.
//   Every input beat produces exactly one output beat, in order.
//
//   N = min(CORDIC_STAGES, 24) is the number of CORDIC cells. Throughput is one
//   beat per cycle while the receiver does not stall: the pipeline is a straight
//   chain of registers, a phase-product and a quadrant-fold stage, one CORDIC cell
//   per stage, a sine/cosine stage, two multiply stages and a round-and-saturate
//   stage.
//
//   The whole pipeline advances together. When the receiver stalls with a
//   result pending, every stage holds and ready on the input side drops;
//   ready is high whenever the output register is empty or being taken.
//   Reset clears only the stage valid bits; no item survives reset.
module euler_yxz_to_quaternion_top
    import eyq_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    eyq_angle_if.sink    angles,
    eyq_quat_if.source   quat
);

    localparam int NCELL = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    // Stages: phase product, quadrant fold, N cells, sin/cos, pairs, triples, output.
    localparam int LAT   = NCELL + 6;
    localparam int PR_W  = 2 * SC_W;       // pair product width
    localparam int TR_W  = PR_W + SC_W;    // triple product width
    localparam int SUM_W = TR_W + 1;
    localparam int RS_W  = SUM_W - 31;     // width after dropping 31 fraction bits

    logic adv;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    logic signed [SC_W-1:0] cx;
    logic signed [SC_W-1:0] sx;
    logic signed [SC_W-1:0] cy;
    logic signed [SC_W-1:0] sy;
    logic signed [SC_W-1:0] cz;
    logic signed [SC_W-1:0] sz;

    // Pair stage: products of the y and x factors, with z's factors carried along.
    logic signed [PR_W-1:0] p_ss_reg;
    logic signed [PR_W-1:0] p_cc_reg;
    logic signed [PR_W-1:0] p_sc_reg;
    logic signed [PR_W-1:0] p_cs_reg;
    logic signed [PR_W-1:0] p_ss_next;
    logic signed [PR_W-1:0] p_cc_next;
    logic signed [PR_W-1:0] p_sc_next;
    logic signed [PR_W-1:0] p_cs_next;
    logic signed [SC_W-1:0] cz_reg;
    logic signed [SC_W-1:0] sz_reg;

    // Triple stage: eight Q45 products.
    logic signed [TR_W-1:0] t_w1_reg;
    logic signed [TR_W-1:0] t_w2_reg;
    logic signed [TR_W-1:0] t_x1_reg;
    logic signed [TR_W-1:0] t_x2_reg;
    logic signed [TR_W-1:0] t_y1_reg;
    logic signed [TR_W-1:0] t_y2_reg;
    logic signed [TR_W-1:0] t_z1_reg;
    logic signed [TR_W-1:0] t_z2_reg;
    logic signed [TR_W-1:0] t_w1_next;
    logic signed [TR_W-1:0] t_w2_next;
    logic signed [TR_W-1:0] t_x1_next;
    logic signed [TR_W-1:0] t_x2_next;
    logic signed [TR_W-1:0] t_y1_next;
    logic signed [TR_W-1:0] t_y2_next;
    logic signed [TR_W-1:0] t_z1_next;
    logic signed [TR_W-1:0] t_z2_next;

    logic signed [Q_W-1:0] qw_reg;
    logic signed [Q_W-1:0] qx_reg;
    logic signed [Q_W-1:0] qy_reg;
    logic signed [Q_W-1:0] qz_reg;
    logic signed [Q_W-1:0] qw_next;
    logic signed [Q_W-1:0] qx_next;
    logic signed [Q_W-1:0] qy_next;
    logic signed [Q_W-1:0] qz_next;

    // Rounds a Q45 sum half up to Q14 and clamps it to plus or minus 1.0.
    function automatic logic signed [Q_W-1:0] to_q14(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        logic signed [RS_W-1:0]  v;
        logic signed [Q_W-1:0]   res;
        r = (s + SUM_W'(64'sd1073741824)) >>> 31;
        v = r[RS_W-1:0];
        if (v > RS_W'(Q14_ONE))
        begin
            res = Q14_ONE;
        end
        else if (v < -RS_W'(Q14_ONE))
        begin
            res = -Q14_ONE;
        end
        else
        begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

    // The pipeline moves whenever the output register is free or being drained.
    assign adv          = !vld_reg[LAT-1] || quat.ready;
    assign angles.ready = adv;

    assign vld_next = {vld_reg[LAT-2:0], angles.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Three identical half-angle sine/cosine chains run side by side.
    eyq_sincos #(
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_sc_x (
        .clk     (clk),
        .en      (adv),
        .angle   (angles.angle_x),
        .cos_out (cx),
        .sin_out (sx)
    );

    eyq_sincos #(
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_sc_y (
        .clk     (clk),
        .en      (adv),
        .angle   (angles.angle_y),
        .cos_out (cy),
        .sin_out (sy)
    );

    eyq_sincos #(
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_sc_z (
        .clk     (clk),
        .en      (adv),
        .angle   (angles.angle_z),
        .cos_out (cz),
        .sin_out (sz)
    );

    assign p_ss_next = sy * sx;
    assign p_cc_next = cy * cx;
    assign p_sc_next = sy * cx;
    assign p_cs_next = cy * sx;

    // quat_w = sy*sx*sz + cy*cx*cz, quat_x = sy*cx*sz + cy*sx*cz,
    // quat_y = sy*cx*cz - cy*sx*sz, quat_z = cy*cx*sz - sy*sx*cz.
    assign t_w1_next = p_ss_reg * sz_reg;
    assign t_w2_next = p_cc_reg * cz_reg;
    assign t_x1_next = p_sc_reg * sz_reg;
    assign t_x2_next = p_cs_reg * cz_reg;
    assign t_y1_next = p_sc_reg * cz_reg;
    assign t_y2_next = p_cs_reg * sz_reg;
    assign t_z1_next = p_cc_reg * sz_reg;
    assign t_z2_next = p_ss_reg * cz_reg;

    assign qw_next = to_q14(SUM_W'(t_w1_reg) + SUM_W'(t_w2_reg));
    assign qx_next = to_q14(SUM_W'(t_x1_reg) + SUM_W'(t_x2_reg));
    assign qy_next = to_q14(SUM_W'(t_y1_reg) - SUM_W'(t_y2_reg));
    assign qz_next = to_q14(SUM_W'(t_z1_reg) - SUM_W'(t_z2_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_ss_reg <= p_ss_next;
            p_cc_reg <= p_cc_next;
            p_sc_reg <= p_sc_next;
            p_cs_reg <= p_cs_next;
            cz_reg   <= cz;
            sz_reg   <= sz;
            t_w1_reg <= t_w1_next;
            t_w2_reg <= t_w2_next;
            t_x1_reg <= t_x1_next;
            t_x2_reg <= t_x2_next;
            t_y1_reg <= t_y1_next;
            t_y2_reg <= t_y2_next;
            t_z1_reg <= t_z1_next;
            t_z2_reg <= t_z2_next;
            qw_reg   <= qw_next;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            qz_reg   <= qz_next;
        end
    end

    assign quat.valid  = vld_reg[LAT-1];
    assign quat.quat_w = qw_reg;
    assign quat.quat_x = qx_reg;
    assign quat.quat_y = qy_reg;
    assign quat.quat_z = qz_reg;

`ifndef SYNTH
    // A stalled pipeline must not lose or create items anywhere in the chain.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits changed during a stall");

    // An item in the last internal stage reaches the output on the next advance.
    a_reach_out: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[LAT-2]) |=> quat.valid)
        else $error("item dropped before the output register");

    // Saturation keeps every component within plus or minus 1.0.
    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid |-> (quat.quat_w <= Q14_ONE && quat.quat_w >= -Q14_ONE &&
                        quat.quat_x <= Q14_ONE && quat.quat_x >= -Q14_ONE &&
                        quat.quat_y <= Q14_ONE && quat.quat_y >= -Q14_ONE &&
                        quat.quat_z <= Q14_ONE && quat.quat_z >= -Q14_ONE))
        else $error("quaternion component outside plus or minus 1.0");
`endif

endmodule

// ===== src/eyq_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation with its own pipeline register.
// Depends on eyq_pkg for the cell state type and the arctangent table.
module eyq_cordic_cell
    import eyq_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic    clk,
    input  logic    en,
    input  cordic_t cin,
    output cordic_t cout
);

    localparam logic [PH_W-1:0] ATAN = atan_turn(SHIFT);

    cordic_t st_reg;
    cordic_t st_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    assign dx = cin.y >>> SHIFT;
    assign dy = cin.x >>> SHIFT;

    always_comb
    begin
        st_next.quad = cin.quad;
        if (!cin.z[PH_W-1])
        begin
            st_next.x = cin.x - dx;
            st_next.y = cin.y + dy;
            st_next.z = cin.z - signed'(ATAN);
        end
        else
        begin
            st_next.x = cin.x + dx;
            st_next.y = cin.y - dy;
            st_next.z = cin.z + signed'(ATAN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign cout = st_reg;

endmodule

// ===== src/eyq_sincos.sv =====
// Cosine and sine of half an angle: phase scaling, quadrant fold, a chain of
// CORDIC cells and quadrant restore. Depends on eyq_pkg and eyq_cordic_cell.
module eyq_sincos
    import eyq_pkg::*;
#(
    parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [ANGLE_WIDTH-1:0] angle,
    output logic signed [SC_W-1:0]        cos_out,
    output logic signed [SC_W-1:0]        sin_out
);

    localparam int NCELL = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    logic [PROD_W-1:0] a_ext;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] phase_rnd;
    logic [PH_W-1:0]   phase;
    logic [PH_W-1:0]   phase_off;
    logic [1:0]        quad;
    logic [PH_W-1:0]   resid;
    cordic_t           init_reg;
    cordic_t           init_next;
    cordic_t           chain [NCELL+1];

    logic signed [XY_W-1:0] cc_full;
    logic signed [XY_W-1:0] ss_full;
    logic signed [SC_W-1:0] cc;
    logic signed [SC_W-1:0] ss;
    logic signed [SC_W-1:0] cos_reg;
    logic signed [SC_W-1:0] cos_next;
    logic signed [SC_W-1:0] sin_reg;
    logic signed [SC_W-1:0] sin_next;

    // Half angle in turn units, kept modulo 2^48 so the phase wraps.
    assign a_ext     = PROD_W'(angle);
    assign prod_next = a_ext * PHASE_K;

    // Fold to the nearest quadrant; residual lies in [-1/8, +1/8) turn.
    assign phase_rnd = prod_reg + PHASE_RND;
    assign phase     = phase_rnd[PROD_W-1:PROD_W-PH_W];
    assign phase_off = phase + EIGHTH_TURN;
    assign quad      = phase_off[PH_W-1:PH_W-2];
    assign resid     = phase - {quad, {(PH_W-2){1'b0}}};

    always_comb
    begin
        init_next.x    = GAIN_INV;
        init_next.y    = '0;
        init_next.z    = signed'(resid);
        init_next.quad = quad;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            init_reg <= init_next;
        end
    end

    assign chain[0] = init_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        eyq_cordic_cell #(
            .SHIFT (i)
        ) u_cell (
            .clk  (clk),
            .en   (en),
            .cin  (chain[i]),
            .cout (chain[i+1])
        );
    end

    // Round half up to Q15.
    assign cc_full = (chain[NCELL].x + XY_W'(16384)) >>> 15;
    assign ss_full = (chain[NCELL].y + XY_W'(16384)) >>> 15;
    assign cc      = cc_full[SC_W-1:0];
    assign ss      = ss_full[SC_W-1:0];

    always_comb
    begin
        case (chain[NCELL].quad)
            QUAD_0:
            begin
                cos_next = cc;
                sin_next = ss;
            end
            QUAD_1:
            begin
                cos_next = -ss;
                sin_next = cc;
            end
            QUAD_2:
            begin
                cos_next = -cc;
                sin_next = -ss;
            end
            default:
            begin
                cos_next = ss;
                sin_next = -cc;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule
